@@ design/hd_pkg.sv @@
package hd_pkg;

  // field widths
  localparam int COORD_W   = 32;
  localparam int HEAD_W    = 19;
  localparam int DIST_W    = 33;
  localparam int SRC_W     = 2;
  localparam int THR_W     = 16;
  localparam int THR_SQ_W  = 2 * THR_W;
  localparam int CFG_DW    = 32;
  localparam int CFG_AW    = 3;

  // internal widths
  localparam int DELTA_W   = COORD_W + 1;
  localparam int MAG_W     = COORD_W;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int SUMSQ_W   = SQ_W + 1;
  localparam int VEC_W     = 64;
  localparam int NORM_PAD  = 29;
  localparam int ANG_BITS  = 30;
  localparam int ANG_W     = 32;
  localparam int FIX_W     = 34;

  // pipeline geometry
  localparam int FRONT_DEPTH = 4;
  localparam int SQRT_STEPS  = 33;
  localparam int ALIGN_DEPTH = FRONT_DEPTH + SQRT_STEPS;

  // angle constants, q.30
  localparam logic signed [FIX_W-1:0] PI_Q30 = 34'sd3373259426;
  localparam int ATAN_DEPTH = 32;
  localparam int ATAN_IDX_W = $clog2(ATAN_DEPTH);
  localparam logic [ANG_BITS-1:0] ATAN_Q30 [ATAN_DEPTH] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
    30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
    30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
    30'd262143,    30'd131071,    30'd65535,     30'd32767,
    30'd16383,     30'd8191,      30'd4095,      30'd2047,
    30'd1023,      30'd511,       30'd255,       30'd127,
    30'd63,        30'd31,        30'd15,        30'd7,
    30'd3,         30'd1,         30'd0,         30'd0
  };

  // register map
  localparam logic REG_NEAR = 1'b0;
  localparam logic REG_ZERO = 1'b1;
  localparam logic [THR_W-1:0] NEAR_RESET = 16'd655;
  localparam logic [THR_W-1:0] ZERO_RESET = 16'd7;

  // how the heading was chosen
  typedef enum logic [SRC_W-1:0] {
    SRC_ANGLE = 2'd0,
    SRC_KEPT  = 2'd1,
    SRC_ZERO  = 2'd2
  } src_t;

  // quadrant information for the angle fix-up
  typedef struct packed {
    logic dx_neg;
    logic dy_pos;
    logic dy_zero;
  } quad_t;

  // request side data that rides along the pipeline
  typedef struct packed {
    logic              has;
    logic [HEAD_W-1:0] heading;
  } side_t;

  // threshold compare results
  typedef struct packed {
    logic near;
    logic zero;
  } thr_flags_t;

endpackage

@@ design/heading_and_distance.sv @@
// result path: a request passes the front stages, the 33-step root pipeline and the
//   result register before its result is strobed, for any CORDIC_STAGES
// throughput: one request per cycle, busy stays low, results cannot be held off
// reset (rst_n low, synchronous): clears all valid bits, drops requests in flight
//   and loads near_threshold 655 and zero_threshold 7
module heading_and_distance #(
  parameter int CORDIC_STAGES = 20,
  parameter int FRAC_BITS     = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              start,
  output logic                              busy,
  input  logic signed [hd_pkg::COORD_W-1:0] in_start_x,
  input  logic signed [hd_pkg::COORD_W-1:0] in_start_y,
  input  logic signed [hd_pkg::HEAD_W-1:0]  in_start_heading,
  input  logic                              in_has_heading,
  input  logic signed [hd_pkg::COORD_W-1:0] in_goal_x,
  input  logic signed [hd_pkg::COORD_W-1:0] in_goal_y,
  // result channel
  output logic                              out_strobe,
  output logic signed [hd_pkg::HEAD_W-1:0]  out_heading,
  output logic [hd_pkg::DIST_W-1:0]         out_distance,
  output logic [hd_pkg::SRC_W-1:0]          out_source,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hd_pkg::CFG_AW-1:0]         paddr,
  input  logic [hd_pkg::CFG_DW-1:0]         pwdata,
  output logic [hd_pkg::CFG_DW-1:0]         prdata,
  output logic                              pready
);
  import hd_pkg::*;

  localparam int FLAG_DEPTH  = ALIGN_DEPTH - FRONT_DEPTH - 1;
  localparam int ANGLE_DEPTH = ALIGN_DEPTH - (FRONT_DEPTH + CORDIC_STAGES + 1);

  logic                     req_valid;
  logic                     cfg_we;
  logic [THR_W-1:0]         near_thr_r, zero_thr_r;
  logic [THR_SQ_W-1:0]      near_sq_r, zero_sq_r;
  logic                     front_valid;
  logic [SUMSQ_W-1:0]       sum_sq;
  logic [MAG_W-1:0]         mag_x, mag_y;
  quad_t                    quad;
  logic                     root_valid;
  logic [DIST_W-1:0]        root;
  logic signed [HEAD_W-1:0] angle, angle_d;
  side_t                    side_in, side_d;
  thr_flags_t               flags_r, flags_d;
  logic signed [HEAD_W-1:0] heading_nxt, heading_r;
  src_t                     source_nxt, source_r;
  logic [DIST_W-1:0]        distance_r;
  logic                     strobe_r;

  // request handshake, a new request every cycle
  assign busy      = 1'b0;
  assign req_valid = start && !busy;

  // configuration writes
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_thr_r <= NEAR_RESET;
      zero_thr_r <= ZERO_RESET;
    end else if (cfg_we) begin
      unique case (paddr[CFG_AW-1])
        REG_NEAR: near_thr_r <= pwdata[THR_W-1:0];
        REG_ZERO: zero_thr_r <= pwdata[THR_W-1:0];
      endcase
    end
  end

  // configuration reads
  always_comb begin
    unique case (paddr[CFG_AW-1])
      REG_NEAR: prdata = CFG_DW'(near_thr_r);
      REG_ZERO: prdata = CFG_DW'(zero_thr_r);
    endcase
  end

  // squared thresholds for exact compare against the sum of squares
  always_ff @(posedge clk) begin
    near_sq_r <= THR_SQ_W'(near_thr_r) * THR_SQ_W'(near_thr_r);
    zero_sq_r <= THR_SQ_W'(zero_thr_r) * THR_SQ_W'(zero_thr_r);
  end

  // differences, squares and normalization
  hd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (req_valid),
    .start_x  (in_start_x),
    .start_y  (in_start_y),
    .goal_x   (in_goal_x),
    .goal_y   (in_goal_y),
    .out_valid(front_valid),
    .sum_sq   (sum_sq),
    .mag_x    (mag_x),
    .mag_y    (mag_y),
    .quad     (quad)
  );

  // distance
  hd_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (front_valid),
    .radicand (sum_sq),
    .out_valid(root_valid),
    .root     (root)
  );

  // heading
  hd_cordic #(
    .CORDIC_STAGES(CORDIC_STAGES),
    .FRAC_BITS    (FRAC_BITS)
  ) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(front_valid),
    .mag_x   (mag_x),
    .mag_y   (mag_y),
    .quad    (quad),
    .heading (angle)
  );

  hd_delay #(
    .WIDTH(HEAD_W),
    .DEPTH(ANGLE_DEPTH)
  ) u_angle_dly (
    .clk (clk),
    .din (angle),
    .dout(angle_d)
  );

  // start heading rides along to the root output
  assign side_in.has     = in_has_heading;
  assign side_in.heading = in_start_heading;

  hd_delay #(
    .WIDTH($bits(side_t)),
    .DEPTH(ALIGN_DEPTH)
  ) u_side_dly (
    .clk (clk),
    .din (side_in),
    .dout(side_d)
  );

  // threshold compares
  always_ff @(posedge clk) begin
    flags_r.near <= (sum_sq < SUMSQ_W'(near_sq_r));
    flags_r.zero <= (sum_sq <= SUMSQ_W'(zero_sq_r));
  end

  hd_delay #(
    .WIDTH($bits(thr_flags_t)),
    .DEPTH(FLAG_DEPTH)
  ) u_flag_dly (
    .clk (clk),
    .din (flags_r),
    .dout(flags_d)
  );

  // heading selection, a kept start heading wins over the zero case
  always_comb begin
    priority if (side_d.has && flags_d.near) begin
      heading_nxt = side_d.heading;
      source_nxt  = SRC_KEPT;
    end else if (flags_d.zero) begin
      heading_nxt = '0;
      source_nxt  = SRC_ZERO;
    end else begin
      heading_nxt = angle_d;
      source_nxt  = SRC_ANGLE;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= root_valid;
    end
  end

  always_ff @(posedge clk) begin
    heading_r  <= heading_nxt;
    source_r   <= source_nxt;
    distance_r <= root;
  end

  assign out_strobe   = strobe_r;
  assign out_heading  = heading_r;
  assign out_distance = distance_r;
  assign out_source   = source_r;

  // a computed heading only comes from points that are apart
  a_angle_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_source == SRC_ANGLE) |-> out_distance != '0)
    else $error("computed heading for coincident points");

endmodule

@@ design/hd_delay.sv @@
module hd_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  if (DEPTH == 0) begin : g_none
    assign dout = din;
  end else begin : g_line
    logic [WIDTH-1:0] line_r [DEPTH];

    // shift line
    always_ff @(posedge clk) begin
      line_r[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        line_r[i] <= line_r[i-1];
      end
    end

    assign dout = line_r[DEPTH-1];
  end

endmodule

@@ design/hd_front.sv @@
module hd_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic signed [hd_pkg::COORD_W-1:0] start_x,
  input  logic signed [hd_pkg::COORD_W-1:0] start_y,
  input  logic signed [hd_pkg::COORD_W-1:0] goal_x,
  input  logic signed [hd_pkg::COORD_W-1:0] goal_y,
  output logic                              out_valid,
  output logic [hd_pkg::SUMSQ_W-1:0]        sum_sq,
  output logic [hd_pkg::MAG_W-1:0]          mag_x,
  output logic [hd_pkg::MAG_W-1:0]          mag_y,
  output hd_pkg::quad_t                     quad
);
  import hd_pkg::*;

  logic [FRONT_DEPTH-1:0]    vld_r;
  logic signed [DELTA_W-1:0] dx_r, dy_r;
  logic [MAG_W-1:0]          ax_r, ay_r, ax_nxt, ay_nxt;
  quad_t                     quad2_r, quad3_r, quad4_r, quad_nxt;
  logic [SQ_W-1:0]           sx_r, sy_r;
  logic [MAG_W-1:0]          na_x, na_y, na_m, na_x_r, na_y_r, na_m_r;
  logic [MAG_W-1:0]          nb_x, nb_y, nb_m, nb_x_r, nb_y_r;
  logic [SUMSQ_W-1:0]        sum_sq_r;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[FRONT_DEPTH-2:0], in_valid};
    end
  end

  // stage 1: differences, exact in 33 bits
  always_ff @(posedge clk) begin
    dx_r <= {goal_x[COORD_W-1], goal_x} - {start_x[COORD_W-1], start_x};
    dy_r <= {goal_y[COORD_W-1], goal_y} - {start_y[COORD_W-1], start_y};
  end

  // stage 2: magnitudes and quadrant
  always_comb begin
    ax_nxt = dx_r[DELTA_W-1] ? MAG_W'(-dx_r) : dx_r[MAG_W-1:0];
    ay_nxt = dy_r[DELTA_W-1] ? MAG_W'(-dy_r) : dy_r[MAG_W-1:0];
    quad_nxt.dx_neg  = dx_r[DELTA_W-1];
    quad_nxt.dy_zero = (dy_r == '0);
    quad_nxt.dy_pos  = !dy_r[DELTA_W-1] && (dy_r != '0);
  end

  always_ff @(posedge clk) begin
    ax_r    <= ax_nxt;
    ay_r    <= ay_nxt;
    quad2_r <= quad_nxt;
  end

  // stage 3: squares, coarse normalize by 16 and 8
  always_comb begin
    na_m = (ax_r > ay_r) ? ax_r : ay_r;
    na_x = ax_r;
    na_y = ay_r;
    if (na_m[MAG_W-1 -: 16] == '0) begin
      na_m = na_m << 16;
      na_x = na_x << 16;
      na_y = na_y << 16;
    end
    if (na_m[MAG_W-1 -: 8] == '0) begin
      na_m = na_m << 8;
      na_x = na_x << 8;
      na_y = na_y << 8;
    end
  end

  always_ff @(posedge clk) begin
    sx_r    <= SQ_W'(ax_r) * SQ_W'(ax_r);
    sy_r    <= SQ_W'(ay_r) * SQ_W'(ay_r);
    na_x_r  <= na_x;
    na_y_r  <= na_y;
    na_m_r  <= na_m;
    quad3_r <= quad2_r;
  end

  // stage 4: sum of squares, fine normalize by 4, 2 and 1
  always_comb begin
    nb_m = na_m_r;
    nb_x = na_x_r;
    nb_y = na_y_r;
    if (nb_m[MAG_W-1 -: 4] == '0) begin
      nb_m = nb_m << 4;
      nb_x = nb_x << 4;
      nb_y = nb_y << 4;
    end
    if (nb_m[MAG_W-1 -: 2] == '0) begin
      nb_m = nb_m << 2;
      nb_x = nb_x << 2;
      nb_y = nb_y << 2;
    end
    if (!nb_m[MAG_W-1]) begin
      nb_x = nb_x << 1;
      nb_y = nb_y << 1;
    end
  end

  always_ff @(posedge clk) begin
    sum_sq_r <= {1'b0, sx_r} + {1'b0, sy_r};
    nb_x_r   <= nb_x;
    nb_y_r   <= nb_y;
    quad4_r  <= quad3_r;
  end

  assign out_valid = vld_r[FRONT_DEPTH-1];
  assign sum_sq    = sum_sq_r;
  assign mag_x     = nb_x_r;
  assign mag_y     = nb_y_r;
  assign quad      = quad4_r;

  // a nonzero vector leaves normalization with its top bit set
  a_norm_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((mag_x | mag_y) != '0) |-> (mag_x[MAG_W-1] || mag_y[MAG_W-1]))
    else $error("normalized magnitude lacks its top bit");

endmodule

@@ design/hd_sqrt.sv @@
module hd_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [hd_pkg::SUMSQ_W-1:0] radicand,
  output logic                       out_valid,
  output logic [hd_pkg::DIST_W-1:0]  root
);
  import hd_pkg::*;

  localparam int REM_W = DIST_W + 3;
  localparam int RAD_W = 2 * SQRT_STEPS;

  logic [SQRT_STEPS-1:0] vld_r;
  logic [DIST_W-1:0]     root_r   [SQRT_STEPS];
  logic [REM_W-1:0]      rem_r    [SQRT_STEPS];
  logic [RAD_W-1:0]      rad_r    [SQRT_STEPS];
  logic [DIST_W-1:0]     root_nxt [SQRT_STEPS];
  logic [REM_W-1:0]      rem_nxt  [SQRT_STEPS];
  logic [RAD_W-1:0]      rad_nxt  [SQRT_STEPS];

  // one root digit per stage, radicand consumed two bits at a time from the top
  always_comb begin
    logic [DIST_W-1:0] root_in;
    logic [REM_W-1:0]  rem_in, rem_sh, trial;
    logic [RAD_W-1:0]  rad_in;
    logic              fits;
    for (int i = 0; i < SQRT_STEPS; i++) begin
      if (i == 0) begin
        root_in = '0;
        rem_in  = '0;
        rad_in  = {1'b0, radicand};
      end else begin
        root_in = root_r[i-1];
        rem_in  = rem_r[i-1];
        rad_in  = rad_r[i-1];
      end
      rem_sh      = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
      trial       = {1'b0, root_in, 2'b01};
      fits        = (rem_sh >= trial);
      rem_nxt[i]  = fits ? (rem_sh - trial) : rem_sh;
      root_nxt[i] = {root_in[DIST_W-2:0], fits};
      rad_nxt[i]  = {rad_in[RAD_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < SQRT_STEPS; i++) begin
      root_r[i] <= root_nxt[i];
      rem_r[i]  <= rem_nxt[i];
      rad_r[i]  <= rad_nxt[i];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[SQRT_STEPS-2:0], in_valid};
    end
  end

  assign out_valid = vld_r[SQRT_STEPS-1];
  assign root      = root_r[SQRT_STEPS-1];

  // the remainder of a floor root never exceeds twice the root
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> rem_r[SQRT_STEPS-1] <= {2'b00, root_r[SQRT_STEPS-1], 1'b0})
    else $error("square root remainder out of bound");

endmodule

@@ design/hd_cordic.sv @@
module hd_cordic #(
  parameter int CORDIC_STAGES = 20,
  parameter int FRAC_BITS     = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic [hd_pkg::MAG_W-1:0]         mag_x,
  input  logic [hd_pkg::MAG_W-1:0]         mag_y,
  input  hd_pkg::quad_t                    quad,
  output logic signed [hd_pkg::HEAD_W-1:0] heading
);
  import hd_pkg::*;

  localparam int SH = ANG_BITS - FRAC_BITS;
  localparam logic signed [FIX_W-1:0] HALF        = FIX_W'(2 ** (SH - 1));
  localparam logic signed [FIX_W-1:0] BASE_PLAIN  = HALF;
  localparam logic signed [FIX_W-1:0] BASE_PI     = PI_Q30 + HALF;
  localparam logic signed [FIX_W-1:0] BASE_NEG_PI = HALF - PI_Q30;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 32'sd1686629713;
  localparam logic signed [ANG_W-1:0] Z_SLACK     = 32'sd2097152;

  logic [CORDIC_STAGES-1:0]  vld_r;
  logic signed [VEC_W-1:0]   x_r   [CORDIC_STAGES];
  logic signed [VEC_W-1:0]   y_r   [CORDIC_STAGES];
  logic signed [ANG_W-1:0]   z_r   [CORDIC_STAGES];
  quad_t                     quad_r[CORDIC_STAGES];
  logic signed [VEC_W-1:0]   x_nxt [CORDIC_STAGES];
  logic signed [VEC_W-1:0]   y_nxt [CORDIC_STAGES];
  logic signed [ANG_W-1:0]   z_nxt [CORDIC_STAGES];
  logic signed [ANG_W-1:0]   th;
  quad_t                     qd;
  logic signed [FIX_W-1:0]   base, th_ext, term, sum, rounded;
  logic                      neg_th, use_th;
  logic signed [HEAD_W-1:0]  head_r;

  // vectoring micro-rotations, one per stage
  always_comb begin
    logic signed [VEC_W-1:0] xi, yi, xs, ys;
    logic signed [ANG_W-1:0] zi, ang;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      if (i == 0) begin
        xi = {{(VEC_W - MAG_W - NORM_PAD){1'b0}}, mag_x, {NORM_PAD{1'b0}}};
        yi = {{(VEC_W - MAG_W - NORM_PAD){1'b0}}, mag_y, {NORM_PAD{1'b0}}};
        zi = '0;
      end else begin
        xi = x_r[i-1];
        yi = y_r[i-1];
        zi = z_r[i-1];
      end
      xs  = xi >>> i;
      ys  = yi >>> i;
      ang = $signed({{(ANG_W - ANG_BITS){1'b0}}, ATAN_Q30[ATAN_IDX_W'(i)]});
      if (!yi[VEC_W-1]) begin
        x_nxt[i] = xi + ys;
        y_nxt[i] = yi - xs;
        z_nxt[i] = zi + ang;
      end else begin
        x_nxt[i] = xi - ys;
        y_nxt[i] = yi + xs;
        z_nxt[i] = zi - ang;
      end
    end
  end

  always_ff @(posedge clk) begin
    quad_r[0] <= quad;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      x_r[i] <= x_nxt[i];
      y_r[i] <= y_nxt[i];
      z_r[i] <= z_nxt[i];
    end
    for (int i = 1; i < CORDIC_STAGES; i++) begin
      quad_r[i] <= quad_r[i-1];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[CORDIC_STAGES-2:0], in_valid};
    end
  end

  // quadrant fix-up and rounding folded into one adder with carry-in
  assign th = z_r[CORDIC_STAGES-1];
  assign qd = quad_r[CORDIC_STAGES-1];

  always_comb begin
    base   = BASE_PLAIN;
    neg_th = 1'b0;
    use_th = 1'b1;
    if (qd.dy_pos) begin
      if (qd.dx_neg) begin
        base   = BASE_PI;
        neg_th = 1'b1;
      end
    end else if (qd.dx_neg) begin
      base = BASE_NEG_PI;
      // negative x axis gives exactly -pi
      if (qd.dy_zero) begin
        use_th = 1'b0;
      end
    end else begin
      neg_th = 1'b1;
    end
    th_ext  = use_th ? FIX_W'(th) : '0;
    term    = neg_th ? ~th_ext : th_ext;
    sum     = base + term + $signed({{(FIX_W-1){1'b0}}, neg_th});
    rounded = sum >>> SH;
  end

  always_ff @(posedge clk) begin
    head_r <= rounded[HEAD_W-1:0];
  end

  assign heading = head_r;

  // first-quadrant angle of a nonzero vector stays within a hair of [0, pi/2]
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[CORDIC_STAGES-1] && (x_r[CORDIC_STAGES-1] != '0) |->
      (th >= -Z_SLACK) && (th <= HALF_PI_Q30 + Z_SLACK))
    else $error("cordic angle outside the first quadrant");

endmodule
